/* hdl/sparse_logistic_regression_assert.svh */
`ifndef SPARSE_LOGISTIC_REGRESSION_ASSERT_SVH
`define SPARSE_LOGISTIC_REGRESSION_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define SLR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SLR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/slr_pkg.sv */
package slr_pkg;

  localparam int INDEX_W = 12;
  localparam int INDEX_DEPTH = 1 << INDEX_W;
  localparam int DATA_W = 32;
  localparam int ACC_W = 48;
  localparam int IN_TDATA_W = 176;
  localparam int OUT_TDATA_W = 48;
  localparam int SIG_W = 25;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_PRED  = 2'd1,
    KIND_GRAD  = 2'd2,
    KIND_READ  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    RK_RAW  = 2'd0,
    RK_SIG  = 2'd1,
    RK_GRAD = 2'd2
  } rkind_e;

  // sigmoid(0..8) in Q1.24
  localparam logic [SIG_W-1:0] SIG_ONE = 25'd16777216;
  localparam logic [SIG_W-1:0] SIG_TABLE [9] = '{
    25'd8388608,  25'd12265128, 25'd14777323, 25'd15981542, 25'd16475457,
    25'd16664929, 25'd16735732, 25'd16761931, 25'd16771590
  };

  function automatic logic signed [ACC_W-1:0] sat48(input logic signed [64:0] v);
    logic signed [ACC_W-1:0] r;
    if ((&v[64:ACC_W-1]) || !(|v[64:ACC_W-1])) begin
      r = v[ACC_W-1:0];
    end else if (v[64]) begin
      r = {1'b1, {(ACC_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(ACC_W-1){1'b1}}};
    end
    return r;
  endfunction

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] v);
    logic signed [DATA_W-1:0] r;
    if ((&v[63:DATA_W-1]) || !(|v[63:DATA_W-1])) begin
      r = v[DATA_W-1:0];
    end else if (v[63]) begin
      r = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(DATA_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

/* hdl/slr_mul.sv */
module slr_mul
  import slr_pkg::*;
#(
  parameter int FRACTION_BITS = 16
) (
  input  logic                      clk_i,
  input  logic signed [DATA_W-1:0]  a_i,
  input  logic signed [DATA_W-1:0]  b_i,
  output logic signed [63:0]        prod_o
);

  logic signed [63:0] full;
  logic signed [63:0] prod_q;

  assign full = 64'(a_i) * 64'(b_i);

  // arithmetic shift rounds toward minus infinity
  always_ff @(posedge clk_i) begin
    prod_q <= full >>> FRACTION_BITS;
  end

  assign prod_o = prod_q;

endmodule

/* hdl/slr_ram.sv */
module slr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/sparse_logistic_regression.sv */
// Sparse logistic regression engine with weight and gradient memories.
// Input stream: tuser carries the item kind, tlast marks the last feature of
// a row, tdata the remaining fields. Output stream: tdata is the 48-bit
// result, tuser its kind (raw score, sigmoid score, gradient readout).
// All products go through one shared 32x32 multiplier with a registered
// output, and one 48-bit saturating adder serves the dot sum and gradient
// updates, so an item passes through a sequence of states: a weight write
//   is stored when taken; a predict feature multiplies, then adds, and the
//   last one then emits the raw score or first interpolates the sigmoid; a
//   gradient feature multiplies twice, then writes back, plus a bias multiply
//   and write-back after the last item; a gradient readout reads, then emits.
// tready is high only while the sequencer waits for an item.
// After reset the gradient memory is cleared, one entry a cycle, over all
// min(FEATURE_COUNT, 4096) entries; no item is taken meanwhile.
// A result waits in the output register while the receiver stalls; the
// next item is still accepted, and only a further result waits for the
// register to drain.
module sparse_logistic_regression
  import slr_pkg::*;
#(
  parameter int FEATURE_COUNT = 4096,
  parameter int FRACTION_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // index, feature_value, write_data, squash, prediction, label,
  // sample_weight, zero fill
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  // kind
  input  logic [1:0]             s_axis_tuser_i,
  input  logic                   s_axis_tlast_i,
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // result
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  // result_kind
  output logic [1:0]             m_axis_tuser_o
);

  `include "sparse_logistic_regression_assert.svh"

  localparam int DEPTH = (FEATURE_COUNT < INDEX_DEPTH) ? FEATURE_COUNT : INDEX_DEPTH;
  localparam int ADDR_W = $clog2(DEPTH);

  typedef enum logic [12:0] {
    ST_CLEAR  = 13'b0000000000001,
    ST_IDLE   = 13'b0000000000010,
    ST_P_MUL  = 13'b0000000000100,
    ST_P_ACC  = 13'b0000000001000,
    ST_S_MUL  = 13'b0000000010000,
    ST_S_FIN  = 13'b0000000100000,
    ST_G_MUL1 = 13'b0000001000000,
    ST_G_MUL2 = 13'b0000010000000,
    ST_G_WB   = 13'b0000100000000,
    ST_G_BMUL = 13'b0001000000000,
    ST_G_BWB  = 13'b0010000000000,
    ST_R_RD   = 13'b0100000000000,
    ST_EMIT   = 13'b1000000000000
  } state_e;

  state_e state_q, state_d;

  // input fields
  kind_e                    in_kind;
  logic [INDEX_W-1:0]       in_index;
  logic signed [DATA_W-1:0] in_fv, in_wd, in_pred, in_label, in_sw;
  logic                     in_squash, in_valid, accept;

  assign in_kind   = kind_e'(s_axis_tuser_i);
  assign in_index  = s_axis_tdata_i[11:0];
  assign in_fv     = s_axis_tdata_i[43:12];
  assign in_wd     = s_axis_tdata_i[75:44];
  assign in_squash = s_axis_tdata_i[76];
  assign in_pred   = s_axis_tdata_i[108:77];
  assign in_label  = s_axis_tdata_i[140:109];
  assign in_sw     = s_axis_tdata_i[172:141];
  assign in_valid  = 32'(in_index) < 32'(FEATURE_COUNT);

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign accept = s_axis_tvalid_i && s_axis_tready_o;

  // captured item
  logic [INDEX_W-1:0]       index_q;
  logic signed [DATA_W-1:0] fv_q, sw_q, resid_q;
  logic                     last_q, squash_q, valid_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      index_q  <= in_index;
      fv_q     <= in_fv;
      sw_q     <= in_sw;
      resid_q  <= sat32(64'(in_pred) - 64'(in_label));
      last_q   <= s_axis_tlast_i;
      squash_q <= in_squash;
      valid_q  <= in_valid;
    end
  end

  // memories
  logic [ADDR_W-1:0]       clr_q, clr_d;
  logic [ADDR_W-1:0]       rd_addr, g_raddr, g_waddr;
  logic                    w_we, g_we;
  logic [DATA_W-1:0]       w_rdata;
  logic [ACC_W-1:0]        g_rdata, g_wdata;

  assign rd_addr = (state_q == ST_IDLE) ? in_index[ADDR_W-1:0] : index_q[ADDR_W-1:0];
  assign g_raddr = (state_q == ST_G_BMUL) ? '0 : rd_addr;
  assign w_we    = accept && (in_kind == KIND_WRITE) && in_valid;

  slr_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_weight_ram (
    .clk_i   (clk_i),
    .we_i    (w_we),
    .waddr_i (in_index[ADDR_W-1:0]),
    .wdata_i (in_wd),
    .raddr_i (rd_addr),
    .rdata_o (w_rdata)
  );

  slr_ram #(
    .WIDTH (ACC_W),
    .DEPTH (DEPTH)
  ) u_grad_ram (
    .clk_i   (clk_i),
    .we_i    (g_we),
    .waddr_i (g_waddr),
    .wdata_i (g_wdata),
    .raddr_i (g_raddr),
    .rdata_o (g_rdata)
  );

  // shared multiplier
  logic signed [DATA_W-1:0] mul_a, mul_b;
  logic signed [63:0]       prod;

  slr_mul #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  // shared saturating adder
  logic signed [ACC_W-1:0] acc_q, acc_d;
  logic signed [ACC_W-1:0] add_a, add_sum;

  assign add_a   = (state_q == ST_P_ACC) ? acc_q : $signed(g_rdata);
  assign add_sum = sat48(65'(add_a) + 65'(prod));

  // sigmoid on the held score
  logic [ACC_W-1:0]         sig_abs;
  logic                     sig_big;
  logic [2:0]               sig_i;
  logic [FRACTION_BITS-1:0] sig_frac;
  logic [SIG_W-1:0]         sig_lo, sig_diff, sig_mag, sig_s;
  logic [ACC_W-1:0]         sig_out;

  always_comb begin
    sig_abs  = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
    sig_big  = sig_abs >= (ACC_W'(8) << FRACTION_BITS);
    sig_i    = sig_abs[FRACTION_BITS+2:FRACTION_BITS];
    sig_frac = sig_abs[FRACTION_BITS-1:0];
    sig_lo   = SIG_TABLE[sig_i];
    sig_diff = SIG_TABLE[4'(sig_i) + 4'd1] - sig_lo;
    sig_mag  = sig_big ? SIG_ONE : sig_lo + prod[SIG_W-1:0];
    sig_s    = acc_q[ACC_W-1] ? SIG_ONE - sig_mag : sig_mag;
    sig_out  = ACC_W'(sig_s >> (24 - FRACTION_BITS));
  end

  // pending result and output register
  logic [ACC_W-1:0] res_q;
  rkind_e           rkind_q;
  logic             out_valid_q;
  logic [ACC_W-1:0] out_data_q;
  rkind_e           out_kind_q;
  logic             slot_free;

  assign slot_free = !out_valid_q || m_axis_tready_i;

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    acc_d   = acc_q;
    mul_a   = '0;
    mul_b   = '0;
    g_we    = 1'b0;
    g_waddr = index_q[ADDR_W-1:0];
    g_wdata = add_sum;
    case (state_q)
      ST_CLEAR: begin
        g_we    = 1'b1;
        g_waddr = clr_q;
        g_wdata = '0;
        clr_d   = clr_q + 1'b1;
        if (clr_q == ADDR_W'(DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          case (in_kind)
            KIND_WRITE: state_d = ST_IDLE;
            KIND_PRED:  state_d = ST_P_MUL;
            KIND_GRAD: begin
              if (in_valid) begin
                state_d = ST_G_MUL1;
              end else if (s_axis_tlast_i) begin
                state_d = ST_G_BMUL;
              end
            end
            KIND_READ:  state_d = ST_R_RD;
            default:    state_d = ST_IDLE;
          endcase
        end
      end
      ST_P_MUL: begin
        mul_a   = valid_q ? $signed(w_rdata) : '0;
        mul_b   = fv_q;
        state_d = ST_P_ACC;
      end
      ST_P_ACC: begin
        if (!last_q) begin
          acc_d   = add_sum;
          state_d = ST_IDLE;
        end else if (squash_q) begin
          acc_d   = add_sum;
          state_d = ST_S_MUL;
        end else begin
          acc_d   = '0;
          state_d = ST_EMIT;
        end
      end
      ST_S_MUL: begin
        mul_a   = $signed(DATA_W'(sig_diff));
        mul_b   = $signed(DATA_W'(sig_frac));
        state_d = ST_S_FIN;
      end
      ST_S_FIN: begin
        acc_d   = '0;
        state_d = ST_EMIT;
      end
      ST_G_MUL1: begin
        mul_a   = resid_q;
        mul_b   = fv_q;
        state_d = ST_G_MUL2;
      end
      ST_G_MUL2: begin
        mul_a   = sat32(prod);
        mul_b   = sw_q;
        state_d = ST_G_WB;
      end
      ST_G_WB: begin
        g_we    = 1'b1;
        state_d = last_q ? ST_G_BMUL : ST_IDLE;
      end
      ST_G_BMUL: begin
        mul_a   = resid_q;
        mul_b   = sw_q;
        state_d = ST_G_BWB;
      end
      ST_G_BWB: begin
        g_we    = 1'b1;
        g_waddr = '0;
        state_d = ST_IDLE;
      end
      ST_R_RD: begin
        g_we    = valid_q;
        g_wdata = '0;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      acc_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      acc_q   <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_P_ACC: begin
        res_q   <= add_sum;
        rkind_q <= RK_RAW;
      end
      ST_S_FIN: begin
        res_q   <= sig_out;
        rkind_q <= RK_SIG;
      end
      ST_R_RD: begin
        res_q   <= valid_q ? g_rdata : '0;
        rkind_q <= RK_GRAD;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_EMIT && slot_free) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_EMIT && slot_free) begin
      out_data_q <= res_q;
      out_kind_q <= rkind_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_kind_q;

  `SLR_ASSERT_NEXT(a_acc_cleared,
                   state_q == ST_P_ACC && last_q && !squash_q, acc_q == '0,
                   "dot sum not cleared after a raw score")
  `SLR_ASSERT_NEXT(a_emit_holds,
                   state_q == ST_EMIT && out_valid_q && !m_axis_tready_i,
                   state_q == ST_EMIT && out_valid_q,
                   "pending result dropped while output stalled")
  `SLR_ASSERT_NOW(a_out_kind,
                  m_axis_tvalid_o,
                  out_kind_q == RK_RAW || out_kind_q == RK_SIG || out_kind_q == RK_GRAD,
                  "result kind out of range")
  `SLR_ASSERT_NOW(a_grad_wb_valid,
                  state_q == ST_G_WB, valid_q,
                  "gradient update for an index beyond the store")

endmodule
